// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the chunk residency table RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define CRT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Implication in the same cycle, sampled on the rising clock edge, off during reset.
`define CRT_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/crt_pkg.sv -----
// Shared types and constants of the chunk residency table.
// Depends on nothing; used by crt_cell and chunk_residency_table.
package crt_pkg;

   // Row of cells: each cell owns every CELL_COUNT-th table entry
   localparam int CELL_COUNT = 4;
   localparam int CELL_W     = 2;

   // Fixed result field widths
   localparam int SLOT_W   = 11;
   localparam int ACTION_W = 2;
   localparam int OP_W     = 2;
   localparam int RSP_W    = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_BEGIN_FRAME = 2'd0;
   localparam logic [OP_W-1:0] OP_TOUCH       = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD        = 2'd2;

   // Action codes reported to software
   localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FILL    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REPLACE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_REGEN   = 2'd3;

   // Per-cell memory control from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_valid;
      logic wr_active;
      logic wr_payload;
      logic valid_bit;
      logic active_bit;
   } cell_ctrl_type;

   // Priority chain handed from cell to cell: first match and first free entry
   typedef struct packed {
      logic              match_hit;
      logic [CELL_W-1:0] match_cell;
      logic              match_lod_diff;
      logic              free_hit;
      logic [CELL_W-1:0] free_cell;
      logic              free_valid;
   } chain_type;

endpackage

// ----- rtl/crt_cell.sv -----
// One cell of the residency table row: a bank of entries with flags and position.
// Depends on crt_pkg; instantiated in a chain by chunk_residency_table.
module crt_cell #(
   parameter int CELL_ID    = 0,
   parameter int ENTRIES    = 2048,
   parameter int DEPTH      = 512,
   parameter int AW         = 9,
   parameter int COORD_BITS = 16,
   parameter int LOD_BITS   = 4
) (
   input  logic                                 clock,
   input  crt_pkg::cell_ctrl_type               ctrl,
   input  logic [AW-1:0]                        addr,
   input  logic [3*COORD_BITS+LOD_BITS-1:0]     key,
   input  crt_pkg::chain_type                   carry_in,
   output crt_pkg::chain_type                   carry_out
);

   localparam int POS_W = 3*COORD_BITS;
   localparam int KEY_W = POS_W + LOD_BITS;
   localparam int CW    = crt_pkg::CELL_W;

   logic             valid_mem  [DEPTH];
   logic             active_mem [DEPTH];
   logic [KEY_W-1:0] pos_mem    [DEPTH];

   logic             rd_valid_ff;
   logic             rd_active_ff;
   logic [KEY_W-1:0] rd_pos_ff;
   logic [AW-1:0]    rd_addr_ff;

   logic in_range;
   logic is_match;
   logic is_free;

   // Write the bank and register the read word
   always_ff @(posedge clock) begin
      if (ctrl.wr_valid) begin
         valid_mem[addr] <= ctrl.valid_bit;
      end
      if (ctrl.wr_active) begin
         active_mem[addr] <= ctrl.active_bit;
      end
      if (ctrl.wr_payload) begin
         pos_mem[addr] <= key;
      end
      if (ctrl.rd_en) begin
         rd_valid_ff  <= valid_mem[addr];
         rd_active_ff <= active_mem[addr];
         rd_pos_ff    <= pos_mem[addr];
         rd_addr_ff   <= addr;
      end
   end

   // Drop rows past the end of the table
   assign in_range = ((32'(rd_addr_ff) * 32'(crt_pkg::CELL_COUNT)) + 32'(CELL_ID))
                     < 32'(ENTRIES);
   assign is_match = in_range && rd_valid_ff && (rd_pos_ff[POS_W-1:0] == key[POS_W-1:0]);
   assign is_free  = in_range && (!rd_valid_ff || !rd_active_ff);

   // Claim the chain if no lower cell has
   always_comb begin
      carry_out = carry_in;
      if (!carry_in.match_hit && is_match) begin
         carry_out.match_hit      = 1'b1;
         carry_out.match_cell     = CW'(CELL_ID);
         carry_out.match_lod_diff = (rd_pos_ff[KEY_W-1:POS_W] != key[KEY_W-1:POS_W]);
      end
      if (!carry_in.free_hit && is_free) begin
         carry_out.free_hit   = 1'b1;
         carry_out.free_cell  = CW'(CELL_ID);
         carry_out.free_valid = rd_valid_ff;
      end
   end

endmodule

// ----- rtl/chunk_residency_table.sv -----
// Chunk residency table: fully associative, first-free replacement.
// req_ channel: one operation beat; tuser = operation, tdata = chunk_x, chunk_y,
// chunk_z, req_lod from the lowest bit up, zero padded to whole bytes.
// rsp_ channel: one result beat per request; tdata = hit, slot, action,
// forced_evict from the lowest bit up, one zero pad bit on top.
// The table is a row of four cells, each a bank of ENTRIES/4 entries.
// touch and load read all banks one row per cycle and pass the first match
// and first free entry down the cell chain; the scan rate is set by the
// single read port of each bank. begin_frame sweeps the active flags.
// An unused operation code answers with zeros. After reset a clearing
// pass over every bank row wipes the flags; req_tready stays low meanwhile.
// The result sits in an output register; the next beat is taken while it
// waits, and the block holds the following result until rsp_tready frees it.
module chunk_residency_table #(
   parameter int ENTRIES    = 2048,
   parameter int COORD_BITS = 16,
   parameter int LOD_BITS   = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // chunk_x, chunk_y, chunk_z, req_lod, zero pad
   input  logic [((3*COORD_BITS+LOD_BITS+7)/8)*8-1:0] req_tdata,
   // operation
   input  logic [crt_pkg::OP_W-1:0]   req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit, slot, action, forced_evict, zero pad
   output logic [crt_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int CELLS  = crt_pkg::CELL_COUNT;
   localparam int CW     = crt_pkg::CELL_W;
   localparam int SLOT_W = crt_pkg::SLOT_W;
   localparam int DEPTH  = (ENTRIES + CELLS - 1) / CELLS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = AW + CW;
   localparam int KEY_W  = 3*COORD_BITS + LOD_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_UPDATE,
      ST_FRAME,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    cell_addr;
   logic             sv_ff, sv_in;
   logic [AW-1:0]    sa_ff, sa_in;
   logic [crt_pkg::OP_W-1:0] op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;

   logic             match_found_ff, match_found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             match_diff_ff, match_diff_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             free_valid_ff, free_valid_in;

   logic                          res_hit_ff, res_hit_in;
   logic [SLOT_W-1:0]             res_slot_ff, res_slot_in;
   logic [crt_pkg::ACTION_W-1:0]  res_action_ff, res_action_in;
   logic                          res_forced_ff, res_forced_in;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [crt_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   crt_pkg::cell_ctrl_type ctrl [CELLS];
   crt_pkg::chain_type     chain [CELLS+1];

   logic [CELLS-1:0]        wr_sel;
   logic [IDX_W-1:0]        wr_idx;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   logic                    wr_full;
   logic                    wr_lod;
   logic                    rd_all;
   logic                    sweep_valid;
   logic                    sweep_active;
   logic                    last_addr;

   assign last_addr  = (addr_ff == AW'(DEPTH - 1));
   assign slot_ext   = {{SLOT_W{1'b0}}, wr_idx};
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer: next state, scan accumulation and result
   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      sv_in          = 1'b0;
      sa_in          = sa_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_diff_in  = match_diff_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      free_valid_in  = free_valid_ff;
      res_hit_in     = res_hit_ff;
      res_slot_in    = res_slot_ff;
      res_action_in  = res_action_ff;
      res_forced_in  = res_forced_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      cell_addr      = addr_ff;
      wr_sel         = '0;
      wr_idx         = '0;
      wr_full        = 1'b0;
      wr_lod         = 1'b0;
      rd_all         = 1'b0;
      sweep_valid    = 1'b0;
      sweep_active   = 1'b0;

      // Keep the first match and first free entry seen in table order
      if (sv_ff) begin
         if (!match_found_ff && chain[CELLS].match_hit) begin
            match_found_in = 1'b1;
            match_idx_in   = {sa_ff, chain[CELLS].match_cell};
            match_diff_in  = chain[CELLS].match_lod_diff;
         end
         if (!free_found_ff && chain[CELLS].free_hit) begin
            free_found_in = 1'b1;
            free_idx_in   = {sa_ff, chain[CELLS].free_cell};
            free_valid_in = chain[CELLS].free_valid;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            sweep_valid  = 1'b1;
            sweep_active = 1'b1;
            if (last_addr) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in          = req_tuser;
               key_in         = req_tdata[KEY_W-1:0];
               addr_in        = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               res_hit_in     = 1'b0;
               res_slot_in    = '0;
               res_action_in  = crt_pkg::ACT_NONE;
               res_forced_in  = 1'b0;
               unique case (req_tuser) inside
                  crt_pkg::OP_BEGIN_FRAME: state_in = ST_FRAME;
                  crt_pkg::OP_TOUCH, crt_pkg::OP_LOAD: state_in = ST_SCAN;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            rd_all = 1'b1;
            sv_in  = 1'b1;
            sa_in  = addr_ff;
            if (last_addr) begin
               state_in = ST_LAST;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (op_ff == crt_pkg::OP_TOUCH) begin
               if (match_found_ff) begin
                  wr_idx     = match_idx_ff;
                  res_hit_in = 1'b1;
               end
            end else if (match_found_ff) begin
               wr_idx        = match_idx_ff;
               wr_lod        = 1'b1;
               res_hit_in    = 1'b1;
               res_action_in = match_diff_ff ? crt_pkg::ACT_REGEN : crt_pkg::ACT_NONE;
            end else if (free_found_ff) begin
               wr_idx        = free_idx_ff;
               wr_full       = 1'b1;
               res_action_in = free_valid_ff ? crt_pkg::ACT_REPLACE : crt_pkg::ACT_FILL;
            end else begin
               wr_full       = 1'b1;
               res_forced_in = 1'b1;
               res_action_in = crt_pkg::ACT_REPLACE;
            end
            res_slot_in = slot_ext[SLOT_W-1:0];
            cell_addr   = wr_idx[IDX_W-1:CW];
            // Touch miss writes nothing
            if (match_found_ff || op_ff == crt_pkg::OP_LOAD) begin
               for (int c = 0; c < CELLS; c++) begin
                  wr_sel[c] = (wr_idx[CW-1:0] == CW'(c));
               end
            end
            state_in = ST_DONE;
         end
         ST_FRAME: begin
            sweep_active = 1'b1;
            if (last_addr) begin
               addr_in  = '0;
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {1'b0, res_forced_ff, res_action_ff, res_slot_ff, res_hit_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   // Drive each cell's bank control
   always_comb begin
      for (int c = 0; c < CELLS; c++) begin
         ctrl[c].rd_en      = rd_all;
         ctrl[c].wr_valid   = sweep_valid || (wr_sel[c] && wr_full);
         ctrl[c].wr_active  = sweep_active || wr_sel[c];
         ctrl[c].wr_payload = wr_sel[c] && (wr_full || wr_lod);
         ctrl[c].valid_bit  = !sweep_valid;
         ctrl[c].active_bit = !sweep_active;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         addr_ff        <= '0;
         sv_ff          <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         res_hit_ff     <= 1'b0;
         res_slot_ff    <= '0;
         res_action_ff  <= crt_pkg::ACT_NONE;
         res_forced_ff  <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         addr_ff        <= addr_in;
         sv_ff          <= sv_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         res_hit_ff     <= res_hit_in;
         res_slot_ff    <= res_slot_in;
         res_action_ff  <= res_action_in;
         res_forced_ff  <= res_forced_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
      sa_ff         <= sa_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      match_idx_ff  <= match_idx_in;
      match_diff_ff <= match_diff_in;
      free_idx_ff   <= free_idx_in;
      free_valid_ff <= free_valid_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Row of cells, priority chain from the lowest cell up
   assign chain[0] = '0;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      crt_cell #(
         .CELL_ID    (g),
         .ENTRIES    (ENTRIES),
         .DEPTH      (DEPTH),
         .AW         (AW),
         .COORD_BITS (COORD_BITS),
         .LOD_BITS   (LOD_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl[g]),
         .addr      (cell_addr),
         .key       (key_ff),
         .carry_in  (chain[g]),
         .carry_out (chain[g+1])
      );
   end

`include "assert_macros.svh"

   `CRT_ASSERT_IMPL(a_scan_data_follows_read, clock, reset, sv_ff,
      $past(state_ff == ST_SCAN), "scan data without a preceding read")
   `CRT_ASSERT(a_single_cell_write, clock, reset,
      (state_ff != ST_UPDATE) || $onehot0(wr_sel), "update writes more than one cell")
   `CRT_ASSERT_IMPL(a_forced_is_slot_zero, clock, reset, res_forced_ff,
      (res_slot_ff == '0) && (res_action_ff == crt_pkg::ACT_REPLACE),
      "forced eviction not at slot zero")
   `CRT_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_tvalid_ff),
      $past(state_ff == ST_DONE), "result raised outside the done state")

endmodule
